[rtl/core/linear_probe_hash_table_unit_assert.svh]
// Assertion macros for the linear probe hash table unit.
// Depends on nothing; taken in by the top level with `include.
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define LPHT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpht assertion failed");

// next-cycle implication
`define LPHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpht assertion failed");

`endif

[rtl/core/lpht_pkg.sv]
// Package for the linear probe hash table unit: widths, codes and state type.
// No dependencies.
package lpht_pkg;

   localparam int SLOT_BITS   = 10;
   localparam int TABLE_SLOTS = 1 << SLOT_BITS;
   localparam int KEY_W       = 48;
   localparam int VALUE_W     = 16;
   localparam int COUNT_W     = SLOT_BITS + 1;
   localparam int LOAD_W      = 7;
   localparam int PROD_W      = COUNT_W + LOAD_W;
   localparam int LOAD_SCALE  = 100;

   typedef logic [1:0] action_type;
   localparam action_type ACT_INSERT = 2'd0;
   localparam action_type ACT_SEARCH = 2'd1;
   localparam action_type ACT_REMOVE = 2'd2;

   typedef logic [1:0] mark_type;
   localparam mark_type MARK_EMPTY   = 2'd0;
   localparam mark_type MARK_USED    = 2'd1;
   localparam mark_type MARK_DELETED = 2'd2;

   typedef logic [2:0] status_type;
   localparam status_type ST_INSERTED  = 3'd0;
   localparam status_type ST_UPDATED   = 3'd1;
   localparam status_type ST_FULL      = 3'd2;
   localparam status_type ST_FOUND     = 3'd3;
   localparam status_type ST_NOT_FOUND = 3'd4;

   typedef enum logic [3:0] {
      S_CLEAR  = 4'b0001,
      S_IDLE   = 4'b0010,
      S_PROBE  = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

endpackage

[rtl/core/linear_probe_hash_table_unit.sv]
// Linear probe hash table unit: open addressing key/value store, one slot probed per cycle.
// Depends on lpht_pkg and linear_probe_hash_table_unit_assert.svh.
//
//  channel   ports                                   handshake
//  request   req_action, req_key, req_value          start & !busy
//  response  rsp_status, rsp_found_value,            rsp_strobe, one cycle
//            rsp_entry_count, rsp_load_percent
//
// A request probes P slots, P = 1..TABLE_SLOTS, through the one registered read per slot
// memory and the one key comparator; action 3 goes from S_IDLE straight to S_FINISH.
// The response strobes in the cycle after the request finishes; start may be
// taken in that same cycle. After reset a clearing pass over all TABLE_SLOTS (1024)
// slots empties the slot marks with busy high. The receiver cannot stall.
`include "linear_probe_hash_table_unit_assert.svh"

module linear_probe_hash_table_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_action,
   input  logic [lpht_pkg::KEY_W-1:0]  req_key,
   input  logic [lpht_pkg::VALUE_W-1:0] req_value,
   output logic                        rsp_strobe,
   output logic [2:0]                  rsp_status,
   output logic [lpht_pkg::VALUE_W-1:0] rsp_found_value,
   output logic [lpht_pkg::COUNT_W-1:0] rsp_entry_count,
   output logic [lpht_pkg::LOAD_W-1:0] rsp_load_percent
);

   localparam int SB      = lpht_pkg::SLOT_BITS;
   localparam int COUNT_W = lpht_pkg::COUNT_W;

   lpht_pkg::state_type state_ff, state_in;

   // slot memories
   logic [lpht_pkg::KEY_W-1:0]   slot_keys_ff   [lpht_pkg::TABLE_SLOTS];
   logic [lpht_pkg::VALUE_W-1:0] slot_values_ff [lpht_pkg::TABLE_SLOTS];
   lpht_pkg::mark_type           slot_marks_ff  [lpht_pkg::TABLE_SLOTS];

   logic [lpht_pkg::KEY_W-1:0]   key_rd_ff;
   logic [lpht_pkg::VALUE_W-1:0] value_rd_ff;
   lpht_pkg::mark_type           mark_rd_ff;

   // request word
   lpht_pkg::action_type         action_ff, action_in;
   logic [lpht_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [lpht_pkg::VALUE_W-1:0] value_ff, value_in;

   // probe state
   logic [SB-1:0]                idx_ff, idx_in;
   logic [SB-1:0]                cnt_ff, cnt_in;
   logic [SB-1:0]                clr_ff, clr_in;
   logic                         hit_ff, hit_in;
   logic [SB-1:0]                hit_idx_ff, hit_idx_in;
   logic [lpht_pkg::VALUE_W-1:0] hit_value_ff, hit_value_in;
   logic                         free_vld_ff, free_vld_in;
   logic [SB-1:0]                free_idx_ff, free_idx_in;
   logic [lpht_pkg::COUNT_W-1:0] count_ff, count_in;

   // response registers
   logic                         rsp_strobe_ff, rsp_strobe_in;
   lpht_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [lpht_pkg::VALUE_W-1:0] rsp_found_ff, rsp_found_in;
   logic [lpht_pkg::COUNT_W-1:0] rsp_count_ff;
   logic [lpht_pkg::LOAD_W-1:0]  rsp_load_ff, rsp_load_in;
   logic [lpht_pkg::PROD_W-1:0]  load_prod;

   // write ports
   logic                         key_we, value_we, mark_we;
   logic [SB-1:0]                value_wa, mark_wa;
   lpht_pkg::mark_type           mark_wd;

   logic                         accept, is_empty, is_used, match, last, done;
   logic                         valid_action;

   assign accept       = start && (state_ff == lpht_pkg::S_IDLE);
   assign busy         = (state_ff != lpht_pkg::S_IDLE);
   assign valid_action = (req_action == lpht_pkg::ACT_INSERT) ||
                         (req_action == lpht_pkg::ACT_SEARCH) ||
                         (req_action == lpht_pkg::ACT_REMOVE);

   assign is_empty = (mark_rd_ff == lpht_pkg::MARK_EMPTY);
   assign is_used  = (mark_rd_ff == lpht_pkg::MARK_USED);
   assign match    = is_used && (key_rd_ff == key_ff);
   assign last     = (cnt_ff == SB'(lpht_pkg::TABLE_SLOTS - 1));
   assign done     = is_empty || match || last;

   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      clr_in       = clr_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_value_in = hit_value_ff;
      free_vld_in  = free_vld_ff;
      free_idx_in  = free_idx_ff;
      count_in     = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = lpht_pkg::ST_NOT_FOUND;
      rsp_found_in  = '0;
      key_we   = 1'b0;
      value_we = 1'b0;
      mark_we  = 1'b0;
      value_wa = hit_ff ? hit_idx_ff : free_idx_ff;
      mark_wa  = clr_ff;
      mark_wd  = lpht_pkg::MARK_EMPTY;

      case (state_ff)
         lpht_pkg::S_CLEAR: begin
            mark_we = 1'b1;
            clr_in  = clr_ff + SB'(1);
            if (clr_ff == SB'(lpht_pkg::TABLE_SLOTS - 1)) begin
               state_in = lpht_pkg::S_IDLE;
            end
         end
         lpht_pkg::S_IDLE: begin
            if (accept) begin
               action_in   = req_action;
               key_in      = req_key;
               value_in    = req_value;
               idx_in      = req_key[SB-1:0];
               cnt_in      = '0;
               hit_in      = 1'b0;
               free_vld_in = 1'b0;
               state_in    = valid_action ? lpht_pkg::S_PROBE : lpht_pkg::S_FINISH;
            end
         end
         lpht_pkg::S_PROBE: begin
            if (!free_vld_ff && !is_used) begin
               free_vld_in = 1'b1;
               free_idx_in = idx_ff;
            end
            if (match) begin
               hit_in       = 1'b1;
               hit_idx_in   = idx_ff;
               hit_value_in = value_rd_ff;
            end
            if (done) begin
               state_in = lpht_pkg::S_FINISH;
            end else begin
               idx_in = idx_ff + SB'(1);
               cnt_in = cnt_ff + SB'(1);
            end
         end
         lpht_pkg::S_FINISH: begin
            state_in      = lpht_pkg::S_IDLE;
            rsp_strobe_in = 1'b1;
            case (action_ff)
               lpht_pkg::ACT_INSERT: begin
                  if (hit_ff) begin
                     value_we      = 1'b1;
                     rsp_status_in = lpht_pkg::ST_UPDATED;
                  end else if (free_vld_ff) begin
                     key_we        = 1'b1;
                     value_we      = 1'b1;
                     mark_we       = 1'b1;
                     mark_wa       = free_idx_ff;
                     mark_wd       = lpht_pkg::MARK_USED;
                     count_in      = count_ff + COUNT_W'(1);
                     rsp_status_in = lpht_pkg::ST_INSERTED;
                  end else begin
                     rsp_status_in = lpht_pkg::ST_FULL;
                  end
               end
               lpht_pkg::ACT_SEARCH: begin
                  if (hit_ff) begin
                     rsp_status_in = lpht_pkg::ST_FOUND;
                     rsp_found_in  = hit_value_ff;
                  end
               end
               lpht_pkg::ACT_REMOVE: begin
                  if (hit_ff) begin
                     mark_we       = 1'b1;
                     mark_wa       = hit_idx_ff;
                     mark_wd       = lpht_pkg::MARK_DELETED;
                     rsp_status_in = lpht_pkg::ST_FOUND;
                     if (count_ff != '0) begin
                        count_in = count_ff - COUNT_W'(1);
                     end
                  end
               end
               default: begin
                  rsp_status_in = lpht_pkg::ST_NOT_FOUND;
               end
            endcase
         end
         default: begin
            state_in = lpht_pkg::S_IDLE;
         end
      endcase
   end

   assign load_prod   = lpht_pkg::PROD_W'(count_in) * lpht_pkg::PROD_W'(lpht_pkg::LOAD_SCALE);
   assign rsp_load_in = lpht_pkg::LOAD_W'(load_prod >> SB);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lpht_pkg::S_CLEAR;
         clr_ff        <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         hit_ff        <= 1'b0;
         free_vld_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
         hit_ff        <= hit_in;
         free_vld_ff   <= free_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff    <= action_in;
      key_ff       <= key_in;
      value_ff     <= value_in;
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      hit_idx_ff   <= hit_idx_in;
      hit_value_ff <= hit_value_in;
      free_idx_ff  <= free_idx_in;
      if (rsp_strobe_in) begin
         rsp_status_ff <= rsp_status_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_count_ff  <= count_in;
         rsp_load_ff   <= rsp_load_in;
      end
   end

   // slot memories: one write, one registered read each
   always_ff @(posedge clock) begin
      if (key_we) begin
         slot_keys_ff[free_idx_ff] <= key_ff;
      end
      key_rd_ff <= slot_keys_ff[idx_in];
   end

   always_ff @(posedge clock) begin
      if (value_we) begin
         slot_values_ff[value_wa] <= value_ff;
      end
      value_rd_ff <= slot_values_ff[idx_in];
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         slot_marks_ff[mark_wa] <= mark_wd;
      end
      mark_rd_ff <= slot_marks_ff[idx_in];
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found_value  = rsp_found_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_load_percent = rsp_load_ff;

   `LPHT_ASSERT_NEXT(a_finish_strobes, clock, reset,
      state_ff == lpht_pkg::S_FINISH, rsp_strobe)
   `LPHT_ASSERT_NEXT(a_single_word, clock, reset, rsp_strobe, !rsp_strobe)
   `LPHT_ASSERT_NEXT(a_accept_runs, clock, reset, start && !busy,
      state_ff == lpht_pkg::S_PROBE || state_ff == lpht_pkg::S_FINISH)
   `LPHT_ASSERT_NOW(a_count_bound, clock, reset, rsp_strobe,
      rsp_entry_count <= COUNT_W'(lpht_pkg::TABLE_SLOTS))

endmodule
